>>> design/ir_ac_frame_codec_assert.svh
// Assertion helpers for the IR frame codec. Both use clk_i and rst_ni of the
// module that includes this file.
`ifndef IR_AC_FRAME_CODEC_ASSERT_SVH
`define IR_AC_FRAME_CODEC_ASSERT_SVH

// Property holds on every edge outside reset.
`define IRAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When pre holds, post holds in the next cycle.
`define IRAC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/irac_pkg.sv
`timescale 1ns / 1ps

package irac_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 11;

  // Power-on frame, byte 0 in the low bits.
  localparam logic [87:0] RESET_FRAME = 88'h6A_95_40_BF_00_FF_D9_26_C3_AE_52;

  localparam int unsigned BYTE_CHECK = 9;
  localparam int unsigned BYTE_STATE = 10;
  localparam int unsigned PWR_BIT    = 3;

  localparam logic [14:0] THRESHOLD_RST = 15'd800;
  localparam logic [1:0]  RX_START_POS  = 2'd3;

  localparam logic [5:0] TEMP_OFFSET = 6'd17;
  localparam logic [5:0] TEMP_MAX    = 6'd32;

  localparam logic signed [12:0] PULSE_HDR_MARK  = 13'sd3300;
  localparam logic signed [12:0] PULSE_HDR_SPACE = -13'sd1650;
  localparam logic signed [12:0] PULSE_LEAD_MARK = 13'sd400;
  localparam logic signed [12:0] PULSE_ONE_SPACE = -13'sd1200;
  localparam logic signed [12:0] PULSE_ZERO_SPACE = -13'sd400;
  localparam logic signed [12:0] PULSE_BIT_MARK  = 13'sd450;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_CMD   = 2'd1,
    OP_FETCH = 2'd2
  } op_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_PULSE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] interval;
    logic               interval_last;
    logic [7:0]         power_cmd;
    logic [7:0]         temp_cmd;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic               power_state;
    logic [5:0]         temperature;
    logic signed [12:0] pulse;
    logic               pulse_last;
  } result_t;

endpackage

>>> design/ir_ac_frame_codec.sv
// IR air-conditioner frame codec: receive decode, command edit, transmit fetch.
// A result passes through the input register and then the result register, and is
// offered on the master side once it has been loaded into the result register.
// Throughput: one item per cycle; the input register advances whenever the
// result register is empty or being emptied.
// Reset (rst_ni low, asynchronous): sample frame, counters zero, threshold 800.
`timescale 1ns / 1ps

module ir_ac_frame_codec #(
  parameter int unsigned FRAME_BYTES = irac_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // interval[15:0], power_cmd[23:16], temp_cmd[31:24]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  input  logic        s_axis_tlast,  // interval_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // power_state[0], temperature[6:1], pulse[19:7], zero
  output logic [0:0]  m_axis_tuser,  // kind[0]
  output logic        m_axis_tlast   // pulse_last
);

  irac_pkg::in_item_t s_item, cur_item;
  irac_pkg::result_t  core_res, out_res;
  logic               cur_valid;
  logic               core_res_valid;
  logic               out_free;
  logic               go;

  assign cfg_ready_o = 1'b1;

  assign s_item.op            = s_axis_tuser;
  assign s_item.interval      = $signed(s_axis_tdata[15:0]);
  assign s_item.interval_last = s_axis_tlast;
  assign s_item.power_cmd     = s_axis_tdata[23:16];
  assign s_item.temp_cmd      = s_axis_tdata[31:24];

  assign go = cur_valid && out_free;

  irac_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (s_item),
    .pop_i   (go),
    .valid_o (cur_valid),
    .item_o  (cur_item)
  );

  irac_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .go_i        (go),
    .item_i      (cur_item),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  irac_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (core_res_valid),
    .res_i   (core_res),
    .free_o  (out_free),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {4'b0000, out_res.pulse, out_res.temperature, out_res.power_state};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.pulse_last;

endmodule

>>> design/irac_in_reg.sv
`timescale 1ns / 1ps

module irac_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  irac_pkg::in_item_t item_i,
  input  logic              pop_i,
  output logic              valid_o,
  output irac_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  irac_pkg::in_item_t item_q;

  assign ready_o = !valid_q || pop_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (pop_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> design/irac_core.sv
`timescale 1ns / 1ps
`include "ir_ac_frame_codec_assert.svh"

module irac_core #(
  parameter int unsigned FRAME_BYTES = irac_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               go_i,
  input  irac_pkg::in_item_t item_i,
  output logic               res_valid_o,
  output irac_pkg::result_t  res_o
);

  localparam int unsigned NBITS = FRAME_BYTES * 8;
  localparam int unsigned BCW   = $clog2(NBITS + 1);
  localparam int unsigned IW    = $clog2(NBITS);
  localparam int unsigned TOTAL = 3 + 2 * NBITS;
  localparam int unsigned TXW   = $clog2(TOTAL);
  localparam int unsigned ST_LO = irac_pkg::BYTE_STATE * 8;
  localparam int unsigned CK_LO = irac_pkg::BYTE_CHECK * 8;

  logic [NBITS-1:0] frame_q, frame_d;
  logic [1:0]       pos_q, pos_d;
  logic [BCW-1:0]   bcnt_q, bcnt_d;
  logic [TXW-1:0]   tx_q, tx_d;
  logic [14:0]      thr_q;

  // receive path
  logic [15:0]      space_len;
  logic             rx_bit;
  logic             take_bit;
  logic [NBITS-1:0] rx_frame;
  logic [BCW-1:0]   rx_cnt;
  logic [NBITS-1:0] rx_done;
  logic [7:0]       rx_state;

  // command path
  logic [7:0]       cmd_state;
  logic             cmd_changed;
  logic [5:0]       temp_sat;

  // transmit path
  logic [TXW-1:0]   tx_k;
  logic             tx_bit;
  logic             tx_last;
  logic signed [12:0] tx_pulse;

  assign space_len = 16'(~$unsigned(item_i.interval) + 16'd1);
  assign rx_bit    = space_len >= {1'b0, thr_q};
  assign take_bit  = (pos_q == irac_pkg::RX_START_POS) && item_i.interval[15]
                     && (bcnt_q < BCW'(NBITS));
  assign rx_cnt    = take_bit ? BCW'(bcnt_q + 1'b1) : bcnt_q;
  assign rx_done   = rx_frame & ~({NBITS{1'b1}} << rx_cnt);
  assign rx_state  = rx_done[ST_LO +: 8];

  always_comb begin
    rx_frame = frame_q;
    if (take_bit) begin
      rx_frame[bcnt_q[IW-1:0]] = rx_bit;
    end
  end

  assign temp_sat = (item_i.temp_cmd > 8'(irac_pkg::TEMP_MAX)) ? irac_pkg::TEMP_MAX
                                                            : item_i.temp_cmd[5:0];

  always_comb begin
    cmd_state   = frame_q[ST_LO +: 8];
    cmd_changed = 1'b0;
    if (item_i.power_cmd == 8'd0) begin
      cmd_state[irac_pkg::PWR_BIT] = 1'b0;
      cmd_changed = 1'b1;
    end else if (item_i.power_cmd == 8'd1) begin
      cmd_state[irac_pkg::PWR_BIT] = 1'b1;
      cmd_changed = 1'b1;
    end
    if (item_i.temp_cmd != 8'd0) begin
      // nibble is (temp - 17) mod 16
      cmd_state[7:4] = 4'(temp_sat - 6'd1);
      cmd_changed = 1'b1;
    end
  end

  assign tx_k    = TXW'(tx_q - TXW'(3));
  assign tx_bit  = frame_q[tx_k[IW:1]];
  assign tx_last = tx_q == TXW'(TOTAL - 1);

  always_comb begin
    if (tx_q == TXW'(0)) begin
      tx_pulse = irac_pkg::PULSE_HDR_MARK;
    end else if (tx_q == TXW'(1)) begin
      tx_pulse = irac_pkg::PULSE_HDR_SPACE;
    end else if (tx_q == TXW'(2)) begin
      tx_pulse = irac_pkg::PULSE_LEAD_MARK;
    end else if (tx_k[0]) begin
      tx_pulse = irac_pkg::PULSE_BIT_MARK;
    end else begin
      tx_pulse = tx_bit ? irac_pkg::PULSE_ONE_SPACE : irac_pkg::PULSE_ZERO_SPACE;
    end
  end

  always_comb begin
    frame_d     = frame_q;
    pos_d       = pos_q;
    bcnt_d      = bcnt_q;
    tx_d        = tx_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (go_i) begin
      unique case (irac_pkg::op_e'(item_i.op))
        irac_pkg::OP_RX: begin
          if (item_i.interval_last) begin
            frame_d           = rx_done;
            pos_d             = 2'd0;
            bcnt_d            = '0;
            res_valid_o       = 1'b1;
            res_o.kind        = irac_pkg::KIND_REPORT;
            res_o.power_state = rx_state[irac_pkg::PWR_BIT];
            res_o.temperature = {2'b00, rx_state[7:4]} + irac_pkg::TEMP_OFFSET;
          end else begin
            frame_d = rx_frame;
            bcnt_d  = rx_cnt;
            if (pos_q != irac_pkg::RX_START_POS) begin
              pos_d = pos_q + 2'd1;
            end
          end
        end
        irac_pkg::OP_CMD: begin
          frame_d[ST_LO +: 8] = cmd_state;
          if (cmd_changed) begin
            frame_d[CK_LO +: 8] = ~cmd_state;
          end
          tx_d = '0;
        end
        irac_pkg::OP_FETCH: begin
          res_valid_o      = 1'b1;
          res_o.kind       = irac_pkg::KIND_PULSE;
          res_o.pulse      = tx_pulse;
          res_o.pulse_last = tx_last;
          tx_d             = tx_last ? '0 : TXW'(tx_q + 1'b1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= NBITS'(irac_pkg::RESET_FRAME);
      pos_q   <= 2'd0;
      bcnt_q  <= '0;
      tx_q    <= '0;
      thr_q   <= irac_pkg::THRESHOLD_RST;
    end else begin
      frame_q <= frame_d;
      pos_q   <= pos_d;
      bcnt_q  <= bcnt_d;
      tx_q    <= tx_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  `IRAC_ASSERT(a_tx_in_range, tx_q < TXW'(TOTAL), "transmit index past end of frame")
  `IRAC_ASSERT(a_bcnt_in_range, bcnt_q <= BCW'(NBITS), "receive bit count past frame")
  `IRAC_ASSERT_NEXT(a_rx_end_clears, go_i && item_i.op == irac_pkg::OP_RX && item_i.interval_last, bcnt_q == '0 && pos_q == 2'd0, "receive counters not cleared at frame end")
  `IRAC_ASSERT_NEXT(a_cmd_restarts_tx, go_i && item_i.op == irac_pkg::OP_CMD, tx_q == '0, "command did not restart transmit")

endmodule

>>> design/irac_out_reg.sv
`timescale 1ns / 1ps

module irac_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  irac_pkg::result_t res_i,
  output logic              free_o,
  input  logic              ready_i,
  output logic              valid_o,
  output irac_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  irac_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
